### rtl/gregorian_day_difference_macros.svh
// ----------------------------------------------------------------------------
// gregorian day difference assertion macros
// shared property wrappers, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DAY_DIFFERENCE_MACROS_SVH
`define GREGORIAN_DAY_DIFFERENCE_MACROS_SVH

// same-cycle implication
`define GDD_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gdd assertion failed");

// delayed implication
`define GDD_ASSERT_D2(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##2 (cons)) \
		else $error("gdd latency assertion failed");

`endif

### rtl/gdd_pkg.sv
// ----------------------------------------------------------------------------
// gdd_pkg
// types, constants and calendar tables for the gregorian day difference block
// ----------------------------------------------------------------------------
package gdd_pkg;

	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int DIFF_W   = 22;
	localparam int COUNT_W  = 23;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_EARLIEST_YEAR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LATEST_YEAR   = 1'd1;

	localparam logic [YEAR_W-1:0] EARLIEST_RESET = 14'd2000;
	localparam logic [YEAR_W-1:0] LATEST_RESET   = 14'd2100;

	// floor(y / 100) = (y * 5243) >> 19 for every 14-bit year
	localparam logic [12:0] RECIP_100  = 13'd5243;
	localparam int          RECIP_SH   = 19;
	localparam int          PROD_W     = YEAR_W + 13;
	localparam int          CENT_W     = 8;

	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} gdd_date_t;

	typedef struct packed {
		logic               valid;
		logic [COUNT_W-1:0] count;
	} gdd_date_info_t;

	// days in the whole months before a month, by count of whole months
	function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] whole);
		logic [8:0] r;
		case (whole)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd59;
			4'd3:    r = 9'd90;
			4'd4:    r = 9'd120;
			4'd5:    r = 9'd151;
			4'd6:    r = 9'd181;
			4'd7:    r = 9'd212;
			4'd8:    r = 9'd243;
			4'd9:    r = 9'd273;
			4'd10:   r = 9'd304;
			4'd11:   r = 9'd334;
			default: r = 9'd365;
		endcase
		return r;
	endfunction

	// month length in a common year
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] r;
		case (m)
			4'd2:                         r = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:      r = 5'd30;
			default:                      r = 5'd31;
		endcase
		return r;
	endfunction

endpackage

### rtl/gregorian_day_difference.sv
// ----------------------------------------------------------------------------
// gregorian_day_difference
// validity, order and absolute day difference of two gregorian dates
// ----------------------------------------------------------------------------
// A date pair is taken when start is high (busy is always low, so one pair
// can be given every cycle). The result passes the input register and the
// result register and appears on the result ports with done high for exactly
// one cycle; the receiver must take it then, as results cannot be held off.
// The two registers surround a single pass of day counting.
// Window registers are written through cfg_we/cfg_index/cfg_data and should
// only change while no pair is in flight.
`include "gregorian_day_difference_macros.svh"

module gregorian_day_difference import gdd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [YEAR_W-1:0]    first_year,
	input  logic [MONTH_W-1:0]   first_month,
	input  logic [DAY_W-1:0]     first_day,
	input  logic [YEAR_W-1:0]    second_year,
	input  logic [MONTH_W-1:0]   second_month,
	input  logic [DAY_W-1:0]     second_day,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [YEAR_W-1:0]    cfg_data,
	output logic                 done,
	output logic                 first_valid,
	output logic                 second_valid,
	output logic                 range_ordered,
	output logic [DIFF_W-1:0]    day_difference
);

	logic [YEAR_W-1:0] earliest_q;
	logic [YEAR_W-1:0] latest_q;

	logic           valid_s1;
	gdd_date_t      first_s1;
	gdd_date_t      second_s1;
	gdd_date_info_t first_info;
	gdd_date_info_t second_info;
	logic [COUNT_W-1:0] diff_raw;
	logic [DIFF_W-1:0]  diff_sat;
	logic               ordered;

	logic              valid_s2;
	logic              first_valid_s2;
	logic              second_valid_s2;
	logic              ordered_s2;
	logic [DIFF_W-1:0] diff_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			earliest_q <= EARLIEST_RESET;
			latest_q   <= LATEST_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_EARLIEST_YEAR: earliest_q <= cfg_data;
				REG_LATEST_YEAR:   latest_q   <= cfg_data;
				default:           ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			first_s1  <= '{year: first_year, month: first_month, day: first_day};
			second_s1 <= '{year: second_year, month: second_month, day: second_day};
		end
	end

	gdd_date u_first (
		.date          (first_s1),
		.earliest_year (earliest_q),
		.latest_year   (latest_q),
		.info          (first_info)
	);

	gdd_date u_second (
		.date          (second_s1),
		.earliest_year (earliest_q),
		.latest_year   (latest_q),
		.info          (second_info)
	);

	assign diff_raw = (first_info.count > second_info.count)
		? first_info.count - second_info.count
		: second_info.count - first_info.count;
	assign diff_sat = diff_raw[COUNT_W-1] ? '1 : diff_raw[DIFF_W-1:0];
	assign ordered  = {first_s1.year, first_s1.month, first_s1.day}
		<= {second_s1.year, second_s1.month, second_s1.day};

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			first_valid_s2  <= first_info.valid;
			second_valid_s2 <= second_info.valid;
			ordered_s2      <= ordered;
			diff_s2         <= diff_sat;
		end
	end

	assign done           = valid_s2;
	assign first_valid    = first_valid_s2;
	assign second_valid   = second_valid_s2;
	assign range_ordered  = ordered_s2;
	assign day_difference = diff_s2;

	`GDD_ASSERT_D2(a_word_latency, start && !busy, done)
	`GDD_ASSERT(a_no_spurious_word, done, $past(start, 2))
	`GDD_ASSERT(a_same_date_ordered,
		done && first_valid && second_valid && (day_difference == '0), range_ordered)
	`GDD_ASSERT(a_valid_needs_window, done && first_valid, earliest_q <= latest_q)

endmodule

### rtl/gdd_date.sv
// ----------------------------------------------------------------------------
// gdd_date
// day count from year 0 and window/calendar validity for one date
// ----------------------------------------------------------------------------
module gdd_date import gdd_pkg::*; (
	input  gdd_date_t         date,
	input  logic [YEAR_W-1:0] earliest_year,
	input  logic [YEAR_W-1:0] latest_year,
	output gdd_date_info_t    info
);

	logic [PROD_W-1:0]  prod;
	logic [CENT_W-1:0]  cent;
	logic               cent_exact;
	logic               quad_exact;
	logic               leap;
	logic [YEAR_W:0]    y_plus3;
	logic [COUNT_W-1:0] y_days;
	logic [CENT_W-1:0]  ceil100;
	logic [CENT_W-3:0]  ceil400;
	logic [MONTH_W-1:0] whole;
	logic [DAY_W-1:0]   len;
	logic               in_window;
	logic               month_ok;

	// reciprocal multiply: quotient by 100 and an exact-remainder flag
	assign prod       = PROD_W'(date.year) * PROD_W'(RECIP_100);
	assign cent       = prod[PROD_W-1:RECIP_SH];
	assign cent_exact = (prod[RECIP_SH-1:11] == '0);
	assign quad_exact = cent_exact && (cent[1:0] == 2'd0);
	assign leap       = (date.year[1:0] == 2'd0) && (!cent_exact || quad_exact);

	assign y_plus3 = {1'b0, date.year} + (YEAR_W+1)'(3);
	assign y_days  = COUNT_W'(date.year) * COUNT_W'(365);
	assign ceil100 = cent + CENT_W'(!cent_exact);
	assign ceil400 = cent[CENT_W-1:2] + (CENT_W-2)'(!quad_exact);

	always_comb begin
		if (date.month == '0) begin
			whole = '0;
		end else if (date.month > MONTH_DEC) begin
			whole = MONTH_DEC;
		end else begin
			whole = date.month - MONTH_W'(1);
		end
	end

	// day count plus one; the common offset cancels in the difference
	assign info.count = y_days
		+ COUNT_W'(y_plus3[YEAR_W:2])
		- COUNT_W'(ceil100)
		+ COUNT_W'(ceil400)
		+ COUNT_W'(days_before(whole))
		+ COUNT_W'(leap && (whole >= MONTH_FEB))
		+ COUNT_W'(date.day);

	always_comb begin
		len = month_len(date.month);
		if (date.month == MONTH_FEB && leap) begin
			len = 5'd29;
		end
	end

	assign in_window  = (date.year >= earliest_year) && (date.year <= latest_year);
	assign month_ok   = date.month inside {[4'd1:4'd12]};
	assign info.valid = in_window && month_ok && (date.day != '0) && (date.day <= len);

endmodule

### bench/tb_gregorian_day_difference.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gregorian_day_difference
// self-checking bench for the gregorian day difference block: directed date
// pairs at the calendar corners, then random pairs under several year windows,
// each result compared field by field against an in-bench day count predictor
// ----------------------------------------------------------------------------
module tb_gregorian_day_difference;
	import gdd_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 4;
	localparam int MAX_REPORTS   = 10;
	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_WORDS   = 90;
	localparam int YEAR_TOP      = (1 << YEAR_W) - 1;
	localparam longint DIFF_SAT  = (longint'(1) << DIFF_W) - 1;

	localparam int CUM_DAYS [13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};
	localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	typedef struct packed {
		bit                first_ok;
		bit                second_ok;
		bit                ordered;
		logic [DIFF_W-1:0] days;
	} span_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	gdd_date_t            first_date;
	gdd_date_t            second_date;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [YEAR_W-1:0]    cfg_data;
	logic                 done;
	logic                 first_valid;
	logic                 second_valid;
	logic                 range_ordered;
	logic [DIFF_W-1:0]    day_difference;

	logic [YEAR_W-1:0] window_lo;
	logic [YEAR_W-1:0] window_hi;
	span_t             span_queue [$];
	int                mismatches;
	int                cycles;
	int                burst_left;

	gregorian_day_difference u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.first_year     (first_date.year),
		.first_month    (first_date.month),
		.first_day      (first_date.day),
		.second_year    (second_date.year),
		.second_month   (second_date.month),
		.second_day     (second_date.day),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.done           (done),
		.first_valid    (first_valid),
		.second_valid   (second_valid),
		.range_ordered  (range_ordered),
		.day_difference (day_difference)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit leap_year(int y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int month_length(int y, int m);
		if (m == 2 && leap_year(y))
			return 29;
		return MONTH_DAYS[m-1];
	endfunction

	function automatic int day_number(gdd_date_t dt);
		int y;
		int whole;
		int n;
		y = dt.year;
		if (dt.month == 0)
			whole = 0;
		else if (dt.month > 12)
			whole = 12;
		else
			whole = dt.month - 1;
		n = y * 365 + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
		n += CUM_DAYS[whole];
		if (whole >= 2 && leap_year(y))
			n += 1;
		n += int'(dt.day) - 1;
		return n;
	endfunction

	function automatic bit date_in_window(gdd_date_t dt, logic [YEAR_W-1:0] lo,
			logic [YEAR_W-1:0] hi);
		if (dt.year < lo || dt.year > hi)
			return 1'b0;
		if (dt.month < 1 || dt.month > 12)
			return 1'b0;
		return (dt.day >= 1) && (int'(dt.day) <= month_length(dt.year, dt.month));
	endfunction

	function automatic span_t predict_span(gdd_date_t a, gdd_date_t b,
			logic [YEAR_W-1:0] lo, logic [YEAR_W-1:0] hi);
		span_t  s;
		longint gap;
		gap = longint'(day_number(a)) - longint'(day_number(b));
		if (gap < 0)
			gap = -gap;
		if (gap > DIFF_SAT)
			gap = DIFF_SAT;
		s.first_ok  = date_in_window(a, lo, hi);
		s.second_ok = date_in_window(b, lo, hi);
		if (a.year != b.year)
			s.ordered = a.year < b.year;
		else if (a.month != b.month)
			s.ordered = a.month < b.month;
		else
			s.ordered = a.day <= b.day;
		s.days = gap[DIFF_W-1:0];
		return s;
	endfunction

	function automatic gdd_date_t mk_date(int y, int m, int d);
		gdd_date_t dt;
		dt.year  = y[YEAR_W-1:0];
		dt.month = m[MONTH_W-1:0];
		dt.day   = d[DAY_W-1:0];
		return dt;
	endfunction

	// result checking and window tracking
	always @(posedge clk) begin
		span_t want;
		if (!arst_n) begin
			window_lo = EARLIEST_RESET;
			window_hi = LATEST_RESET;
		end else begin
			if (done) begin
				if (span_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected word: valid %0b/%0b ordered %0b diff %0d",
							first_valid, second_valid, range_ordered, day_difference);
				end else begin
					want = span_queue.pop_front();
					if (first_valid !== want.first_ok || second_valid !== want.second_ok ||
							range_ordered !== want.ordered || day_difference !== want.days) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("mismatch: valid %0b/%0b ordered %0b diff %0d, %s %0b/%0b %0b %0d",
								first_valid, second_valid, range_ordered, day_difference,
								"expected", want.first_ok, want.second_ok, want.ordered,
								want.days);
					end
				end
			end
			if (start && !busy)
				span_queue.push_back(predict_span(first_date, second_date, window_lo, window_hi));
			if (cfg_we) begin
				case (cfg_index)
					REG_EARLIEST_YEAR: window_lo = cfg_data;
					REG_LATEST_YEAR:   window_hi = cfg_data;
					default: ;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("gregorian_day_difference test failed");
			$finish;
		end
	end

	task automatic send_pair(gdd_date_t a, gdd_date_t b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start       <= 1'b1;
		first_date  <= a;
		second_date <= b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic go_idle();
		start <= 1'b0;
		@(posedge clk);
		while (span_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_window_reg(logic [CFG_IDX_W-1:0] idx, logic [YEAR_W-1:0] val);
		go_idle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_window(int lo, int hi);
		write_window_reg(REG_EARLIEST_YEAR, lo[YEAR_W-1:0]);
		write_window_reg(REG_LATEST_YEAR, hi[YEAR_W-1:0]);
	endtask

	function automatic gdd_date_t random_date(int lo, int hi);
		int kind;
		int y;
		int m;
		kind = $urandom_range(0, 9);
		if (kind < 7) begin
			y = (lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(0, 9999);
			m = $urandom_range(1, 12);
			return mk_date(y, m, $urandom_range(1, month_length(y, m)));
		end else if (kind == 7) begin
			case ($urandom_range(0, 3))
				0:       y = lo - 1;
				1:       y = lo;
				2:       y = hi;
				default: y = hi + 1;
			endcase
			return mk_date(y, $urandom_range(1, 12), $urandom_range(0, 31));
		end
		return mk_date($urandom, $urandom, $urandom);
	endfunction

	// second date often shares year or month with the first
	function automatic gdd_date_t random_partner(gdd_date_t a, int lo, int hi);
		gdd_date_t b;
		b = random_date(lo, hi);
		case ($urandom_range(0, 9))
			0, 1: b.year = a.year;
			2, 3: begin
				b.year  = a.year;
				b.month = a.month;
			end
			4: b = a;
			default: ;
		endcase
		return b;
	endfunction

	task automatic test_reset_window_dates();
		send_pair(mk_date(2000, 1, 1), mk_date(2100, 12, 31));
		send_pair(mk_date(1999, 12, 31), mk_date(2101, 1, 1));
		send_pair(mk_date(2000, 2, 29), mk_date(2100, 2, 29));
		send_pair(mk_date(2004, 2, 29), mk_date(2001, 2, 29));
		send_pair(mk_date(2050, 0, 10), mk_date(2050, 13, 10));
		send_pair(mk_date(2050, 15, 1), mk_date(2050, 1, 0));
		send_pair(mk_date(2030, 4, 31), mk_date(2030, 4, 30));
		send_pair(mk_date(2030, 6, 15), mk_date(2030, 6, 15));
		send_pair(mk_date(2030, 6, 16), mk_date(2030, 6, 15));
		send_pair(mk_date(2030, 7, 1), mk_date(2030, 6, 30));
		send_pair(mk_date(0, 3, 1), mk_date(0, 1, 1));
		send_pair(mk_date(YEAR_TOP, 15, 31), mk_date(0, 0, 0));
		send_pair(mk_date(0, 0, 0), mk_date(YEAR_TOP, 12, 31));
		send_pair(mk_date(2100, 12, 31), mk_date(2000, 1, 1));
		send_pair(mk_date(1900, 2, 29), mk_date(2000, 2, 29));
		send_pair(mk_date(2024, 2, 30), mk_date(2024, 3, 1));
	endtask

	task automatic test_window_limits();
		set_window(0, YEAR_TOP);
		send_pair(mk_date(0, 1, 1), mk_date(YEAR_TOP, 12, 31));
		send_pair(mk_date(YEAR_TOP, 2, 29), mk_date(0, 2, 29));
		send_pair(mk_date(9999, 12, 31), mk_date(1, 1, 1));
		// single year window
		set_window(1600, 1600);
		send_pair(mk_date(1600, 2, 29), mk_date(1601, 1, 1));
		send_pair(mk_date(1599, 12, 31), mk_date(1600, 12, 31));
		// empty window
		set_window(YEAR_TOP, 0);
		send_pair(mk_date(0, 1, 1), mk_date(YEAR_TOP, 1, 1));
		send_pair(mk_date(2000, 6, 1), mk_date(2000, 6, 2));
		set_window(5000, 4999);
		send_pair(mk_date(5000, 1, 1), mk_date(4999, 12, 31));
		send_pair(mk_date(4999, 1, 1), mk_date(5000, 12, 31));
	endtask

	task automatic test_random_pairs();
		int lo;
		int hi;
		gdd_date_t a;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == 0) begin
				lo = 0;
				hi = YEAR_TOP;
			end else begin
				lo = $urandom_range(0, 9999);
				hi = $urandom_range(lo, 9999);
			end
			set_window(lo, hi);
			for (int i = 0; i < PHASE_WORDS; i++) begin
				a = random_date(lo, hi);
				send_pair(a, random_partner(a, lo, hi));
			end
		end
	endtask

	initial begin
		mismatches = 0;
		cycles     = 0;
		burst_left = 0;
		arst_n      <= 1'b0;
		start       <= 1'b0;
		first_date  <= '0;
		second_date <= '0;
		cfg_we      <= 1'b0;
		cfg_index   <= REG_EARLIEST_YEAR;
		cfg_data    <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_window_dates();
		test_window_limits();
		test_random_pairs();

		go_idle();
		mismatches += span_queue.size();
		if (mismatches == 0)
			$display("gregorian_day_difference test passed");
		else
			$display("gregorian_day_difference test failed");
		$finish;
	end

endmodule
